### src/rgbxy_pkg.sv
// Shared constants, register codes and elaboration-time table builders for the
// sRGB to CIE xy chromaticity converter. No dependencies.
`timescale 1ns / 1ps

package rgbxy_pkg;

    // Default fixed-point formats.
    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_BITS_DEF = 18;

    // Field widths fixed by the interface.
    localparam int IN_BITS  = 8;
    localparam int OUT_BITS = 16;
    // Quotient bits: one integer bit, sixteen fraction bits and one rounding bit.
    localparam int Q_BITS   = OUT_BITS + 2;

    // Reset values of the white point registers (0.3127, 0.3290).
    localparam logic [OUT_BITS-1:0] WHITE_X_RST = 16'd20493;
    localparam logic [OUT_BITS-1:0] WHITE_Y_RST = 16'd21561;

    // Register index on the configuration port.
    typedef enum logic {
        REG_WHITE_X = 1'b0,
        REG_WHITE_Y = 1'b1
    } reg_idx_t;

    // Linear RGB to XYZ matrix in millionths, rows X, Y, Z.
    localparam logic [19:0] MAT_MICRO [9] = '{
        20'd664511, 20'd154324, 20'd162028,
        20'd283881, 20'd668433, 20'd47685,
        20'd88,     20'd72310,  20'd986039
    };

    localparam logic [63:0] ONE30 = 64'd1 << 30;

    // Fifth power in Q0.30, each product truncated.
    function automatic logic [63:0] pow5_q30(input logic [63:0] v);
        logic [63:0] p;
        int          k;
        p = v;
        for (k = 0; k < 4; k++) begin
            p = (p * v) >> 30;
        end
        return p;
    endfunction

    // Linear light of one 8-bit code in Q0.30. The upper segment raises the
    // normalized code to 2.4 as t^2 times the fifth root of t^2.
    function automatic logic [63:0] linear_q30(input int code);
        logic [63:0] c64;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] w;
        logic [63:0] cand;
        logic [63:0] res;
        int          b;
        c64 = 64'(code);
        w   = '0;
        if (code <= 10) begin
            res = (((c64 * 64'd100) << 30) + 64'd164730) / 64'd329460;
        end else begin
            t  = (((c64 * 64'd1000 + 64'd14025) << 30) + 64'd134512) / 64'd269025;
            t2 = (t * t) >> 30;
            for (b = 30; b >= 0; b--) begin
                cand = w | (64'd1 << b);
                if (cand <= ONE30 && pow5_q30(cand) <= t2) begin
                    w = cand;
                end
            end
            res = (t2 * w) >> 30;
        end
        return res;
    endfunction

    // Table entry rounded half up to the given number of fraction bits.
    function automatic logic [24:0] lin_entry(input int code, input int frac);
        logic [63:0] l;
        l = linear_q30(code);
        return 25'((l + (64'd1 << (29 - frac))) >> (30 - frac));
    endfunction

    // Matrix coefficient rounded to the given number of fraction bits.
    function automatic logic [23:0] coef_entry(input int idx, input int coefb);
        return 24'(((64'(MAT_MICRO[idx]) << coefb) + 64'd500000) / 64'd1000000);
    endfunction

endpackage

### src/rgb_to_xy_chromaticity.sv
// Top level of the sRGB to CIE xy chromaticity converter: linearization table,
// matrix, pipelined restoring dividers, output register with skid, APB registers.
// Depends on rgbxy_pkg.
`timescale 1ns / 1ps

// Usage
// The slave stream takes one RGB word per cycle while s_tready is high (8 bits
// per channel). The master stream returns x and y in unsigned Q0.16 plus a flag
// in tuser that marks a black input, for which the programmed default white
// point is sent. The APB port holds the default white x (offset 0x0) and y
// (offset 0x4). Throughput is one word per clock while s_tready stays high.
// Each word passes through the table lookup, the nine multipliers, the row
// sums and the total, and the two restoring dividers at one quotient bit per
// stage, after which rounding feeds the output register.
// Reset clears every valid bit and loads the reset white point; no word is
// in flight afterwards. When the receiver stalls, the word that leaves the
// pipeline is parked in a one-word skid register and the whole pipeline then
// freezes, with s_tready low, until the output register is taken.
module rgb_to_xy_chromaticity
    import rgbxy_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_level [7:0], green_level [15:8], blue_level [23:16]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // chroma_x [15:0], chroma_y [31:16]
    output logic [0:0]  m_tuser,   // used_default [0]
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW   = FRAC_BITS + 1;   // linear value, up to 1.0
    localparam int CW   = COEF_BITS;
    localparam int PW   = LW + CW;         // one product
    localparam int TRW  = PW + 2;          // one tristimulus sum
    localparam int TOTW = TRW + 2;         // X + Y + Z
    localparam int RW   = TOTW + 1;        // trial remainder

    // Pipeline advances unless a word is parked in the skid register.
    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------------------------------------------------------------
    // Configuration registers.
    // ---------------------------------------------------------------------
    logic [OUT_BITS-1:0] white_x_reg;
    logic [OUT_BITS-1:0] white_y_reg;
    logic                cfg_wr;
    reg_idx_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            white_x_reg <= WHITE_X_RST;
            white_y_reg <= WHITE_Y_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WHITE_X: white_x_reg <= pwdata[OUT_BITS-1:0];
                REG_WHITE_Y: white_y_reg <= pwdata[OUT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WHITE_X: prdata = 32'(white_x_reg);
            REG_WHITE_Y: prdata = 32'(white_y_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Stage 1: linearization table lookup for the three channels.
    // ---------------------------------------------------------------------
    logic [LW-1:0]      lin_tab [256];
    logic [IN_BITS-1:0] chan [3];
    logic [LW-1:0]      lin_reg [3];
    logic               v1_reg;

    for (genvar v = 0; v < 256; v++) begin : g_tab
        assign lin_tab[v] = LW'(lin_entry(v, FRAC_BITS));
    end

    assign chan[0] = s_tdata[7:0];
    assign chan[1] = s_tdata[15:8];
    assign chan[2] = s_tdata[23:16];

    for (genvar c = 0; c < 3; c++) begin : g_lin
        always_ff @(posedge aclk) begin
            if (en) begin
                lin_reg[c] <= lin_tab[chan[c]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: the nine matrix products.
    // ---------------------------------------------------------------------
    logic [PW-1:0] prod_reg [9];
    logic          v2_reg;

    for (genvar i = 0; i < 9; i++) begin : g_mul
        localparam logic [CW-1:0] COEF = CW'(coef_entry(i, COEF_BITS));
        always_ff @(posedge aclk) begin
            if (en) begin
                prod_reg[i] <= PW'(lin_reg[i % 3] * COEF);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: row sums give X, Y and Z.
    // ---------------------------------------------------------------------
    logic [TRW-1:0] tri_reg [3];
    logic           v3_reg;

    for (genvar r = 0; r < 3; r++) begin : g_row
        always_ff @(posedge aclk) begin
            if (en) begin
                tri_reg[r] <= TRW'(prod_reg[3*r]) + TRW'(prod_reg[3*r+1])
                            + TRW'(prod_reg[3*r+2]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: total and black detection.
    // ---------------------------------------------------------------------
    logic [TOTW-1:0] tot_next;
    logic [TOTW-1:0] tot_reg;
    logic [TRW-1:0]  num_x_reg;
    logic [TRW-1:0]  num_y_reg;
    logic            zero4_reg;
    logic            v4_reg;

    assign tot_next = TOTW'(tri_reg[0]) + TOTW'(tri_reg[1]) + TOTW'(tri_reg[2]);

    always_ff @(posedge aclk) begin
        if (en) begin
            tot_reg   <= tot_next;
            num_x_reg <= tri_reg[0];
            num_y_reg <= tri_reg[1];
            zero4_reg <= (tot_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Restoring dividers for X/total and Y/total, one quotient bit per stage.
    // The first stage tests the integer bit without a shift.
    // ---------------------------------------------------------------------
    logic [TOTW-1:0]   rem_x_reg [Q_BITS];
    logic [TOTW-1:0]   rem_y_reg [Q_BITS];
    logic [TOTW-1:0]   den_reg   [Q_BITS];
    logic [Q_BITS-1:0] q_x_reg   [Q_BITS];
    logic [Q_BITS-1:0] q_y_reg   [Q_BITS];
    logic              dzero_reg [Q_BITS];
    logic              dvalid_reg [Q_BITS];

    for (genvar k = 0; k < Q_BITS; k++) begin : g_div
        logic [RW-1:0]     rx_try;
        logic [RW-1:0]     ry_try;
        logic [RW-1:0]     den_ext;
        logic [RW-1:0]     diff_x;
        logic [RW-1:0]     diff_y;
        logic [TOTW-1:0]   den_in;
        logic [Q_BITS-1:0] qx_in;
        logic [Q_BITS-1:0] qy_in;
        logic              zero_in;
        logic              valid_in;
        logic              ge_x;
        logic              ge_y;
        logic [TOTW-1:0]   rem_x_next;
        logic [TOTW-1:0]   rem_y_next;

        if (k == 0) begin : g_first
            assign rx_try   = RW'(num_x_reg);
            assign ry_try   = RW'(num_y_reg);
            assign den_in   = tot_reg;
            assign qx_in    = '0;
            assign qy_in    = '0;
            assign zero_in  = zero4_reg;
            assign valid_in = v4_reg;
        end else begin : g_rest
            assign rx_try   = {rem_x_reg[k-1], 1'b0};
            assign ry_try   = {rem_y_reg[k-1], 1'b0};
            assign den_in   = den_reg[k-1];
            assign qx_in    = q_x_reg[k-1];
            assign qy_in    = q_y_reg[k-1];
            assign zero_in  = dzero_reg[k-1];
            assign valid_in = dvalid_reg[k-1];
        end

        // Trial subtraction; the remainder stays below the divisor.
        assign den_ext    = {1'b0, den_in};
        assign ge_x       = rx_try >= den_ext;
        assign ge_y       = ry_try >= den_ext;
        assign diff_x     = rx_try - den_ext;
        assign diff_y     = ry_try - den_ext;
        assign rem_x_next = ge_x ? diff_x[TOTW-1:0] : rx_try[TOTW-1:0];
        assign rem_y_next = ge_y ? diff_y[TOTW-1:0] : ry_try[TOTW-1:0];

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_x_reg[k] <= rem_x_next;
                rem_y_reg[k] <= rem_y_next;
                den_reg[k]   <= den_in;
                q_x_reg[k]   <= {qx_in[Q_BITS-2:0], ge_x};
                q_y_reg[k]   <= {qy_in[Q_BITS-2:0], ge_y};
                dzero_reg[k] <= zero_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dvalid_reg[k] <= 1'b0;
            end else if (en) begin
                dvalid_reg[k] <= valid_in;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Rounding, saturation and the black-input default.
    // ---------------------------------------------------------------------
    logic [Q_BITS:0]     qsum_x;
    logic [Q_BITS:0]     qsum_y;
    logic [OUT_BITS-1:0] res_x;
    logic [OUT_BITS-1:0] res_y;
    logic                res_def;
    logic                res_valid;

    assign qsum_x    = {1'b0, q_x_reg[Q_BITS-1]} + (Q_BITS+1)'(1);
    assign qsum_y    = {1'b0, q_y_reg[Q_BITS-1]} + (Q_BITS+1)'(1);
    assign res_def   = dzero_reg[Q_BITS-1];
    assign res_valid = dvalid_reg[Q_BITS-1];

    always_comb begin
        if (res_def) begin
            res_x = white_x_reg;
            res_y = white_y_reg;
        end else begin
            res_x = (|qsum_x[Q_BITS:OUT_BITS+1]) ? '1 : qsum_x[OUT_BITS:1];
            res_y = (|qsum_y[Q_BITS:OUT_BITS+1]) ? '1 : qsum_y[OUT_BITS:1];
        end
    end

    // ---------------------------------------------------------------------
    // Output register and skid register.
    // ---------------------------------------------------------------------
    logic                out_valid_reg;
    logic [OUT_BITS-1:0] out_x_reg;
    logic [OUT_BITS-1:0] out_y_reg;
    logic                out_def_reg;
    logic [OUT_BITS-1:0] skid_x_reg;
    logic [OUT_BITS-1:0] skid_y_reg;
    logic                skid_def_reg;
    logic                out_hold;

    assign out_hold = out_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_hold) begin
            // Output is blocked: a word leaving the pipeline is parked.
            if (en && res_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_hold) begin
            if (en && res_valid) begin
                skid_x_reg   <= res_x;
                skid_y_reg   <= res_y;
                skid_def_reg <= res_def;
            end
        end else if (skid_valid_reg) begin
            out_x_reg   <= skid_x_reg;
            out_y_reg   <= skid_y_reg;
            out_def_reg <= skid_def_reg;
        end else begin
            out_x_reg   <= res_x;
            out_y_reg   <= res_y;
            out_def_reg <= res_def;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tuser  = out_def_reg;

endmodule

### src/rgbxy_checker.sv
// Port-level checks for the chromaticity converter and the bind that attaches
// them to rgb_to_xy_chromaticity. No package dependencies.
`timescale 1ns / 1ps

module rgbxy_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled word stays valid.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // A stalled word keeps its payload.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // x + y never exceeds one, allowing one LSB for the two roundings.
    a_xy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            ({1'b0, m_tdata[15:0]} + {1'b0, m_tdata[31:16]}) <= 17'd65537)
        else $error("x plus y exceeds one");

    // Input back-pressure only happens behind a pending result word.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("word still present after reset");

endmodule

bind rgb_to_xy_chromaticity rgbxy_checker u_rgbxy_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/rgb_to_xy_chromaticity_tb.sv
// Self-checking testbench for rgb_to_xy_chromaticity: random RGB words against an
// in-bench chromaticity predictor, with random stalls on both streams.
// Depends on rgbxy_pkg and the rgb_to_xy_chromaticity top level.
`timescale 1ns / 1ps

module rgb_to_xy_chromaticity_tb;
    import rgbxy_pkg::*;

    localparam int FRAC_B       = 16;
    localparam int COEF_B       = 18;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_WORDS  = 270;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic        dflt;
    } chroma_t;

    logic        aclk     = 1'b1;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // red_level [7:0], green_level [15:8], blue_level [23:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // chroma_x [15:0], chroma_y [31:16]
    logic [0:0]  m_tuser;         // used_default [0]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Linearization table, matrix coefficients and shadow white point.
    logic [63:0] lin_lut [256];
    logic [63:0] mat_q [9];
    logic [15:0] white_x_cfg = WHITE_X_RST;
    logic [15:0] white_y_cfg = WHITE_Y_RST;

    logic [23:0] pending_words [$];
    chroma_t     chroma_due [$];
    bit          word_busy = 1'b0;
    int          send_wait = 0;
    int          send_run  = 0;
    int          recv_wait = 0;
    int          recv_run  = 0;
    int          fail_count = 0;
    int          idle_cycles = 0;

    rgb_to_xy_chromaticity #(
        .FRAC_BITS(FRAC_B),
        .COEF_BITS(COEF_B)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Fifth power in Q0.30 with every product truncated.
    function automatic logic [63:0] trunc_pow5(input logic [63:0] base);
        logic [63:0] acc;
        acc = base;
        repeat (4) acc = (acc * base) >> 30;
        return acc;
    endfunction

    // sRGB decode of one code to linear light in Q0.30.
    function automatic logic [63:0] srgb_decode_q30(input int code);
        logic [63:0] cv;
        logic [63:0] norm;
        logic [63:0] sq;
        logic [63:0] root;
        logic [63:0] trial;
        int          b;
        cv   = 64'(code);
        root = '0;
        if (code <= 10) begin
            return ((cv * 64'd100 << 30) + 64'd164730) / 64'd329460;
        end
        norm = (((cv * 64'd1000 + 64'd14025) << 30) + 64'd134512) / 64'd269025;
        sq   = (norm * norm) >> 30;
        // Fifth root of the square, found bit by bit from the top.
        for (b = 30; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial <= (64'd1 << 30) && trunc_pow5(trial) <= sq) root = trial;
        end
        return (sq * root) >> 30;
    endfunction

    function automatic void build_tables();
        logic [63:0] l;
        logic [19:0] micro [9];
        int          i;
        micro = '{20'd664511, 20'd154324, 20'd162028,
                  20'd283881, 20'd668433, 20'd47685,
                  20'd88,     20'd72310,  20'd986039};
        for (i = 0; i < 256; i++) begin
            l = srgb_decode_q30(i);
            lin_lut[i] = (l + (64'd1 << (29 - FRAC_B))) >> (30 - FRAC_B);
        end
        for (i = 0; i < 9; i++) begin
            mat_q[i] = ((64'(micro[i]) << COEF_B) + 64'd500000) / 64'd1000000;
        end
    endfunction

    // Ratio rounded half up to Q0.16 and saturated. The numerator never
    // exceeds the denominator here, so a plain division gives the quotient.
    function automatic logic [15:0] ratio_u16(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        q = ((num << 17) / den + 64'd1) >> 1;
        return (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic chroma_t predict_chroma(input logic [23:0] word);
        logic [63:0] lin [3];
        logic [63:0] tri_v [3];
        logic [63:0] total;
        chroma_t     res;
        int          row;
        int          col;
        lin[0] = lin_lut[word[7:0]];
        lin[1] = lin_lut[word[15:8]];
        lin[2] = lin_lut[word[23:16]];
        for (row = 0; row < 3; row++) begin
            tri_v[row] = '0;
            for (col = 0; col < 3; col++) begin
                tri_v[row] += lin[col] * mat_q[row * 3 + col];
            end
        end
        total = tri_v[0] + tri_v[1] + tri_v[2];
        if (total == 0) begin
            res.cx   = white_x_cfg;
            res.cy   = white_y_cfg;
            res.dflt = 1'b1;
        end else begin
            res.cx   = ratio_u16(tri_v[0], total);
            res.cy   = ratio_u16(tri_v[1], total);
            res.dflt = 1'b0;
        end
        return res;
    endfunction

    // Wait before the next word: mostly drawn uniformly at random, with occasional gap-free runs.
    function automatic int draw_wait(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) begin
            run = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Input side: one word from the queue at a time, held until accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                chroma_due.push_back(predict_chroma(s_tdata));
                word_busy = 1'b0;
            end
            if (send_wait > 0) begin
                send_wait--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                s_tdata   <= pending_words.pop_front();
                s_tvalid  <= 1'b1;
                word_busy = 1'b1;
                send_wait = draw_wait(send_run);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side: compare each word with the oldest prediction, stall at random.
    always @(posedge aclk) begin
        chroma_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            if (chroma_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result word: x=%0d y=%0d default=%0b",
                             m_tdata[15:0], m_tdata[31:16], m_tuser[0]);
                end
            end else begin
                want = chroma_due.pop_front();
                if (m_tdata[15:0] !== want.cx || m_tdata[31:16] !== want.cy ||
                    m_tuser[0] !== want.dflt) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: expected x=%0d y=%0d default=%0b, got x=%0d y=%0d default=%0b",
                                 want.cx, want.cy, want.dflt,
                                 m_tdata[15:0], m_tdata[31:16], m_tuser[0]);
                    end
                end
            end
            recv_wait = draw_wait(recv_run);
            m_tready <= (recv_wait == 0);
        end else if (recv_wait > 0) begin
            recv_wait--;
            m_tready <= (recv_wait == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("rgb_to_xy_chromaticity verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // APB write: setup cycle, then access cycle; junk in the upper data bits.
    task automatic reg_write(input reg_idx_t idx, input logic [15:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx) << 2;
        pwdata  <= {16'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WHITE_X) white_x_cfg = value;
        else white_y_cfg = value;
    endtask

    task automatic set_white(input logic [15:0] wx, input logic [15:0] wy);
        reg_write(REG_WHITE_X, wx);
        reg_write(REG_WHITE_Y, wy);
    endtask

    // Sender holds off until every predicted word has come back.
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_words.size() != 0 || word_busy || chroma_due.size() != 0);
    endtask

    // Random words: black, dark codes near the linear segment, single channels, full range.
    task automatic queue_random(input int n);
        int          i;
        int          kind;
        logic [23:0] w;
        for (i = 0; i < n; i++) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                w = '0;
            end else if (kind <= 3) begin
                w = {8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                     8'($urandom_range(0, 12))};
            end else if (kind == 4) begin
                w = 24'($urandom_range(0, 255)) << (8 * $urandom_range(0, 2));
            end else begin
                w = 24'($urandom);
            end
            pending_words.push_back(w);
        end
    endtask

    initial begin
        logic [23:0] directed [$];
        build_tables();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words at the reset white point: black, white, primaries,
        // codes at both ends of the linear segment, alternating bit patterns.
        directed = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                     24'h000001, 24'h000100, 24'h010000, 24'h010101, 24'h0A0A0A,
                     24'h0B0B0B, 24'h0C0B0A, 24'h00FFFF, 24'hFF00FF, 24'hFFFF00,
                     24'h808080, 24'h555555, 24'hAAAAAA, 24'h000000, 24'h7F7F7F};
        foreach (directed[i]) pending_words.push_back(directed[i]);
        wait_drained();

        // Random phases under several white points, extremes among them.
        set_white(16'h0000, 16'hFFFF);
        pending_words.push_back(24'h000000);
        queue_random(PHASE_WORDS);
        wait_drained();

        set_white(16'hFFFF, 16'h0000);
        pending_words.push_back(24'h000000);
        queue_random(PHASE_WORDS);
        wait_drained();

        set_white(16'($urandom), 16'($urandom));
        pending_words.push_back(24'h000000);
        queue_random(PHASE_WORDS);
        wait_drained();

        set_white(16'hFFFF, 16'hFFFF);
        pending_words.push_back(24'h000000);
        queue_random(PHASE_WORDS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && chroma_due.size() == 0) begin
            $display("rgb_to_xy_chromaticity verification clean");
        end else begin
            $display("rgb_to_xy_chromaticity verification failed");
        end
        $finish;
    end

endmodule
